@@ sv/sfir_pkg.sv @@
// Shared types and constants for the stereo FIR filter.
package sfir_pkg;

  // Payload widths of the sample and result items.
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 24;
  localparam int CIDX_W     = 10;
  localparam int TAP_CNT_W  = 11;
  localparam int PROD_W     = SAMPLE_W + COEF_W;

  // Q3.45 products are brought back to Q1.23 by this shift.
  localparam int FRAC_SHIFT = 22;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_TAP_COUNT = 1'b0;

  // Item kinds carried in the action field.
  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_LOAD   = 1'b1;

  // Control that travels with each tap beat through the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic zero;
  } mac_ctrl_t;

endpackage

@@ sv/sfir_in_if.sv @@
// Input channel carrying sample pairs and coefficient loads.
interface sfir_in_if;
  import sfir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic [CIDX_W-1:0]          coef_index;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (
    output valid, action, left_sample, right_sample, coef_index, coef_value,
    input  ready
  );

  modport sink (
    input  valid, action, left_sample, right_sample, coef_index, coef_value,
    output ready
  );

endinterface

@@ sv/sfir_out_if.sv @@
// Output channel carrying filtered stereo sample pairs.
interface sfir_out_if;
  import sfir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  modport source (
    output valid, left_out, right_out,
    input  ready
  );

  modport sink (
    input  valid, left_out, right_out,
    output ready
  );

endinterface

@@ sv/stereo_fir_filter_top.sv @@
// Top level of the stereo FIR filter: control sequencer, register port and output stage.
//
//   channel   direction  handshake        item
//   smp_i     in         valid / ready    sample pair or coefficient load
//   res_o     out        valid / ready    filtered left and right sample
//   APB       in         psel / penable   tap_count register at address 0
//
// A sample item reads the L taps in use one per cycle from the single read
// port of each memory, then passes the multiply, accumulate and rounding
// stages; a load item is written to memory in the cycle it is taken. After
// reset a clearing pass zeroes both memories, and no item is taken until it
// ends. A result waits in the output register while the next item is taken;
// a later result waits for it to leave.
module stereo_fir_filter_top #(
  parameter int MAX_TAPS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfir_in_if.sink                         smp_i,
  sfir_out_if.source                      res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfir_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sfir_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sfir_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import sfir_pkg::*;

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int LEN_W = $clog2(MAX_TAPS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [TAP_CNT_W-1:0] tap_count_q, tap_count_d;
  logic [AW-1:0]        wp_q, wp_d;
  logic [AW-1:0]        j_q, j_d;
  logic [AW-1:0]        hidx_q, hidx_d;
  mac_ctrl_t            ctl_d, ctl_q;

  logic                 out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_l_q, out_r_q;

  logic [LEN_W-1:0]     len;
  logic [31:0]          len32, wp1, start32;
  logic                 clr_busy, accept, cfg_wr, out_free, beat_last;

  logic                 hist_we, coef_we;
  logic [AW-1:0]        coef_waddr;
  logic [2*SAMPLE_W-1:0] hist_rdata;
  logic [COEF_W-1:0]    coef_rdata;

  logic                 mac_done;
  logic signed [SAMPLE_W-1:0] mac_l, mac_r;

  // Register port: one register, writes take effect in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    tap_count_d = tap_count_q;
    if (cfg_wr && (paddr[2] == REG_TAP_COUNT)) begin
      tap_count_d = pwdata[TAP_CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_TAP_COUNT) begin
      prdata = APB_DATA_W'(tap_count_q);
    end else begin
      prdata = '0;
    end
  end

  // Taps in use, clamped to the delay line depth.
  always_comb begin
    if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
      len32 = 32'(MAX_TAPS);
    end else begin
      len32 = 32'(tap_count_q);
    end
    len = len32[LEN_W-1:0];
  end

  // Oldest sample position once the new pair is written at the write position.
  always_comb begin
    wp1 = 32'(wp_q) + 32'd1;
    if (len == '0) begin
      start32 = '0;
    end else if (wp1 >= len32) begin
      start32 = wp1 - len32;
    end else begin
      start32 = wp1 + 32'(MAX_TAPS) - len32;
    end
  end

  assign smp_i.ready = (state_q == ST_IDLE) && !clr_busy;
  assign accept      = smp_i.valid & smp_i.ready;
  assign hist_we     = accept && (smp_i.action == ACTION_SAMPLE);
  assign coef_we     = accept && (smp_i.action == ACTION_LOAD) &&
                       (32'(smp_i.coef_index) < 32'(MAX_TAPS));
  assign coef_waddr  = AW'(smp_i.coef_index);
  assign beat_last   = (32'(j_q) + 32'd1 >= len32);
  assign out_free    = !out_valid_q || res_o.ready;

  // Sequencer: one tap read per cycle, then wait for the pipeline to drain.
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    j_d         = j_q;
    hidx_d      = hidx_q;
    ctl_d       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (hist_we) begin
          j_d     = '0;
          hidx_d  = start32[AW-1:0];
          wp_d    = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl_d.valid = 1'b1;
        ctl_d.first = (j_q == '0);
        ctl_d.last  = beat_last;
        ctl_d.zero  = (len == '0);
        if (beat_last) begin
          state_d = ST_WAIT;
        end else begin
          j_d    = j_q + 1'b1;
          hidx_d = (hidx_q == AW'(MAX_TAPS - 1)) ? '0 : hidx_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= '0;
      wp_q        <= '0;
      j_q         <= '0;
      hidx_q      <= '0;
      ctl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_count_q <= tap_count_d;
      wp_q        <= wp_d;
      j_q         <= j_d;
      hidx_q      <= hidx_d;
      ctl_q       <= ctl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register loads when the finished result moves across.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && out_free) begin
      out_l_q <= mac_l;
      out_r_q <= mac_r;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.left_out  = out_l_q;
  assign res_o.right_out = out_r_q;

  sfir_store #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_busy_o   (clr_busy),
    .hist_we_i    (hist_we),
    .hist_waddr_i (wp_q),
    .hist_wdata_i ({smp_i.left_sample, smp_i.right_sample}),
    .hist_raddr_i (hidx_q),
    .hist_rdata_o (hist_rdata),
    .coef_we_i    (coef_we),
    .coef_waddr_i (coef_waddr),
    .coef_wdata_i (smp_i.coef_value),
    .coef_raddr_i (j_q),
    .coef_rdata_o (coef_rdata)
  );

  // Read data is registered, so it arrives in the cycle after the address, together with ctl_q.
  sfir_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_q),
    .coef_i  (coef_rdata),
    .left_i  (hist_rdata[2*SAMPLE_W-1:SAMPLE_W]),
    .right_i (hist_rdata[SAMPLE_W-1:0]),
    .done_o  (mac_done),
    .left_o  (mac_l),
    .right_o (mac_r)
  );

endmodule

@@ sv/sfir_store.sv @@
// Delay line and coefficient memories with the clearing pass after reset.
module sfir_store #(
  parameter int MAX_TAPS = 1024,
  parameter int AW       = $clog2(MAX_TAPS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  output logic                                clr_busy_o,
  input  logic                                hist_we_i,
  input  logic [AW-1:0]                       hist_waddr_i,
  input  logic [2*sfir_pkg::SAMPLE_W-1:0]     hist_wdata_i,
  input  logic [AW-1:0]                       hist_raddr_i,
  output logic [2*sfir_pkg::SAMPLE_W-1:0]     hist_rdata_o,
  input  logic                                coef_we_i,
  input  logic [AW-1:0]                       coef_waddr_i,
  input  logic [sfir_pkg::COEF_W-1:0]         coef_wdata_i,
  input  logic [AW-1:0]                       coef_raddr_i,
  output logic [sfir_pkg::COEF_W-1:0]         coef_rdata_o
);
  import sfir_pkg::*;

  // Left and right history share one word; coefficients live in a second memory.
  logic [2*SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic [COEF_W-1:0]     coef_mem [MAX_TAPS];

  logic                  clr_q, clr_d;
  logic [AW-1:0]         clr_addr_q, clr_addr_d;

  logic                  hist_we, coef_we;
  logic [AW-1:0]         hist_addr, coef_addr;
  logic [2*SAMPLE_W-1:0] hist_data;
  logic [COEF_W-1:0]     coef_data;

  logic [2*SAMPLE_W-1:0] hist_rdata_q;
  logic [COEF_W-1:0]     coef_rdata_q;

  // The clearing pass zeroes one entry of both memories per cycle.
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == AW'(MAX_TAPS - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The clearing pass owns the write ports while it runs.
  always_comb begin
    hist_we   = clr_q | hist_we_i;
    hist_addr = clr_q ? clr_addr_q : hist_waddr_i;
    hist_data = clr_q ? '0 : hist_wdata_i;
    coef_we   = clr_q | coef_we_i;
    coef_addr = clr_q ? clr_addr_q : coef_waddr_i;
    coef_data = clr_q ? '0 : coef_wdata_i;
  end

  // Synchronous write and registered read for both memories.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_addr] <= hist_data;
    end
    hist_rdata_q <= hist_mem[hist_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_addr] <= coef_data;
    end
    coef_rdata_q <= coef_mem[coef_raddr_i];
  end

  assign hist_rdata_o = hist_rdata_q;
  assign coef_rdata_o = coef_rdata_q;
  assign clr_busy_o   = clr_q;

endmodule

@@ sv/sfir_mac.sv @@
// Two-lane multiply-accumulate pipeline with rounding and saturation to Q1.23.
module sfir_mac #(
  parameter int MAX_TAPS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sfir_pkg::mac_ctrl_t                ctl_i,
  input  logic signed [sfir_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0] right_i,
  output logic                               done_o,
  output logic signed [sfir_pkg::SAMPLE_W-1:0] left_o,
  output logic signed [sfir_pkg::SAMPLE_W-1:0] right_o
);
  import sfir_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
  localparam int SH_W  = ACC_W - FRAC_SHIFT;

  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};
  localparam logic signed [SH_W-1:0] QMAX =
    {{(SH_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] QMIN =
    {{(SH_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

  mac_ctrl_t                 ctl1_q, ctl2_q;
  logic signed [PROD_W-1:0]  prod_l_q, prod_r_q;
  logic signed [ACC_W-1:0]   acc_l_q, acc_r_q, acc_l_d, acc_r_d;
  logic signed [ACC_W-1:0]   sum_l, sum_r;
  logic signed [SH_W-1:0]    sh_l, sh_r;
  logic signed [SAMPLE_W-1:0] sat_l, sat_r;
  logic signed [SAMPLE_W-1:0] res_l_q, res_r_q;
  logic                      done_q;

  // Control follows the data through the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.valid & ctl2_q.last;
    end
  end

  // Stage one: products; an empty filter contributes zero.
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      if (ctl_i.zero) begin
        prod_l_q <= '0;
        prod_r_q <= '0;
      end else begin
        prod_l_q <= PROD_W'(coef_i) * PROD_W'(left_i);
        prod_r_q <= PROD_W'(coef_i) * PROD_W'(right_i);
      end
    end
  end

  // Stage two: accumulate, restarting on the first tap.
  always_comb begin
    if (ctl1_q.first) begin
      acc_l_d = ACC_W'(prod_l_q);
      acc_r_d = ACC_W'(prod_r_q);
    end else begin
      acc_l_d = acc_l_q + ACC_W'(prod_l_q);
      acc_r_d = acc_r_q + ACC_W'(prod_r_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl1_q.valid) begin
      acc_l_q <= acc_l_d;
      acc_r_q <= acc_r_d;
    end
  end

  // Stage three: round half up, shift down and clamp to the Q1.23 range.
  always_comb begin
    sum_l = acc_l_q + RND;
    sum_r = acc_r_q + RND;
    sh_l  = sum_l[ACC_W-1:FRAC_SHIFT];
    sh_r  = sum_r[ACC_W-1:FRAC_SHIFT];
    if (sh_l > QMAX) begin
      sat_l = QMAX[SAMPLE_W-1:0];
    end else if (sh_l < QMIN) begin
      sat_l = QMIN[SAMPLE_W-1:0];
    end else begin
      sat_l = sh_l[SAMPLE_W-1:0];
    end
    if (sh_r > QMAX) begin
      sat_r = QMAX[SAMPLE_W-1:0];
    end else if (sh_r < QMIN) begin
      sat_r = QMIN[SAMPLE_W-1:0];
    end else begin
      sat_r = sh_r[SAMPLE_W-1:0];
    end
  end

  // The result holds until the next item's last tap arrives.
  always_ff @(posedge clk_i) begin
    if (ctl2_q.valid && ctl2_q.last) begin
      res_l_q <= sat_l;
      res_r_q <= sat_r;
    end
  end

  assign done_o  = done_q;
  assign left_o  = res_l_q;
  assign right_o = res_r_q;

endmodule
